### design/assert_macros.svh
// Assertion macros shared by the timer RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/mstt_pkg.sv
// Package for the multi-slot task timer: codes, defaults and the status struct.
// No dependencies.
package mstt_pkg;

  localparam int unsigned SlotsDef    = 8;
  localparam int unsigned DelayMaxDef = 4095;
  localparam int unsigned DelayW      = 16;
  localparam int unsigned SlotW       = 5;
  localparam int unsigned OutcomeW    = 3;

  // input kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_ONCE   = 2'd1;
  localparam logic [1:0] KIND_REPEAT = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  // time units
  localparam logic [1:0] UNIT_US = 2'd0;
  localparam logic [1:0] UNIT_MS = 2'd1;
  localparam logic [1:0] UNIT_S  = 2'd2;

  // outcomes
  localparam logic [2:0] OUT_FIRED     = 3'd0;
  localparam logic [2:0] OUT_SCHEDULED = 3'd1;
  localparam logic [2:0] OUT_NO_SLOT   = 3'd2;
  localparam logic [2:0] OUT_CANCELLED = 3'd3;
  localparam logic [2:0] OUT_NONE      = 3'd4;
  localparam logic [2:0] OUT_IGNORED   = 3'd5;

  // result handed from the sequencer to the output stage
  typedef struct packed {
    logic [2:0] outcome;
    logic [4:0] slot;
    logic       last;
  } result_t;

endpackage

### design/mstt_div1000.sv
// Divide of a 24-bit amount by 1000 through one reciprocal multiplication.
// Depends on mstt_pkg and assert_macros.svh.
module mstt_div1000 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] dividend_i,
  output logic        done_o,
  output logic [23:0] quotient_o
);
  import mstt_pkg::*;

  // ceil(2^34 / 1000); the rounding error stays below one for any 24-bit dividend
  localparam logic [24:0] RECIP_1000 = 25'd17179870;

  logic [23:0] dvd_q;
  logic        busy_q;
  logic [48:0] prod;

  // quotient is ready the cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) dvd_q <= dividend_i;
  end

  // one 24x25 product, the quotient is its top bits
  assign prod       = 49'(dvd_q) * 49'(RECIP_1000);
  assign done_o     = busy_q;
  assign quotient_o = {9'd0, prod[48:34]};

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_start_done, clk_i, rst_ni, start_i, done_o)
  `ASSERT_NEXT(a_done_only_start, clk_i, rst_ni, !start_i, !done_o)
  `ASSERT_ALWAYS(a_quot_range, clk_i, rst_ni, done_o |-> (quotient_o <= 24'd16777))
endmodule

### design/multi_slot_task_timer_top.sv
// Multi-slot task timer: top level with sequencer, slot table and output register.
// Depends on mstt_pkg, mstt_div1000 and assert_macros.svh.

// A tick is taken, then every slot is scanned, one a cycle, through one shared
// subtract and compare unit; then a pass over the slots picks the most overdue
// ready slot and the emit state registers its firing, pick and emit repeating
// for each firing; when nothing fires, the emit state registers an OUT_NONE
// result. A millisecond amount above DELAY_MAX is turned into seconds by the
// reciprocal divide by 1000 before it is scheduled. A cancel is answered from
// the idle state. Each result waits in an output register; the sequencer stalls
// in its schedule and emit states while it is held, and a new transaction is
// taken once the sequencer is idle and that register is free.
module multi_slot_task_timer_top #(
  parameter int unsigned SLOTS     = mstt_pkg::SlotsDef,
  parameter int unsigned DELAY_MAX = mstt_pkg::DelayMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [23:0] delay_amount_i,
  input  logic [1:0]  time_unit_i,
  input  logic [4:0]  slot_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  outcome_o,
  output logic [4:0]  slot_o,
  output logic        last_o
);
  import mstt_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DW = $clog2(DELAY_MAX + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_SCHED = 3'd5;

  // counters and slot table
  logic [31:0] micro_q, milli_q;
  logic [9:0]  pre_q;
  logic [31:0] start_q [SLOTS];
  logic [DW-1:0] delay_q [SLOTS];
  logic [1:0]  unit_q [SLOTS];
  logic [SLOTS-1:0] busy_q, per_q, ready_q;
  logic [41:0] late_q [SLOTS];

  logic [2:0]  st_q;
  logic [SW-1:0] idx_q;
  logic        pick_v_q;
  logic [SW-1:0] pick_q;
  logic [41:0] best_q;
  logic        fired_q;
  logic        per_in_q;
  logic [1:0]  su_q;
  logic [23:0] amt_q;
  logic [SW-1:0] free_q;

  result_t res_q;
  logic    rv_q;
  logic    out_take;
  assign out_take    = rv_q && !out_stall_i;
  assign out_valid_o = rv_q;
  assign outcome_o   = res_q.outcome;
  assign slot_o      = res_q.slot;
  assign last_o      = res_q.last;

  // output register free for a new result this cycle
  logic can_put;
  assign can_put = !rv_q || !out_stall_i;

  logic in_take;
  assign in_stall_o = (st_q != ST_IDLE) || !can_put;
  assign in_take    = in_valid_i && !in_stall_o;

  // lowest free slot
  logic          free_any;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // a result enters the output register this cycle
  logic res_put;
  assign res_put = (st_q == ST_IDLE && in_take &&
                    (kind_i == KIND_CANCEL ||
                     ((kind_i == KIND_ONCE || kind_i == KIND_REPEAT) && !free_any))) ||
                   (st_q == ST_SCHED && can_put) ||
                   (st_q == ST_EMIT && can_put && (pick_v_q || !fired_q));

  // shared elapsed/compare unit on slot idx_q
  logic [31:0] now_s, elapsed, need;
  logic [31:0] diff;
  logic        rdy;
  logic [41:0] late;
  always_comb begin
    now_s   = (unit_q[idx_q] == UNIT_US) ? micro_q : milli_q;
    elapsed = now_s - start_q[idx_q];
    need    = (unit_q[idx_q] == UNIT_S) ? 32'(delay_q[idx_q]) * 32'd1000
                                        : 32'(delay_q[idx_q]);
    diff    = elapsed - need;
    rdy     = busy_q[idx_q] && (elapsed >= need);
    late    = (unit_q[idx_q] == UNIT_US) ? 42'(diff)
                                         : ({10'd0, diff} << 10) - ({10'd0, diff} << 4)
                                           - ({10'd0, diff} << 3);
  end

  // divider for millisecond conversion
  logic        div_done;
  logic [23:0] div_q;
  mstt_div1000 u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_take && (kind_i == KIND_ONCE || kind_i == KIND_REPEAT) &&
                time_unit_i == UNIT_MS && delay_amount_i > 24'(DELAY_MAX) && free_any),
    .dividend_i(delay_amount_i),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  logic last_idx;
  assign last_idx = (32'(idx_q) == SLOTS - 1);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      micro_q  <= '0;
      milli_q  <= '0;
      pre_q    <= '0;
      busy_q   <= '0;
      per_q    <= '0;
      ready_q  <= '0;
      idx_q    <= '0;
      pick_v_q <= 1'b0;
      fired_q  <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      if (res_put) rv_q <= 1'b1;
      else if (out_take) rv_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (in_take) begin
            unique case (kind_i)
              KIND_TICK: begin
                micro_q <= micro_q + 32'd1;
                if (pre_q == 10'd999) begin
                  pre_q   <= '0;
                  milli_q <= milli_q + 32'd1;
                end else begin
                  pre_q <= pre_q + 10'd1;
                end
                idx_q   <= '0;
                fired_q <= 1'b0;
                st_q    <= ST_SCAN;
              end
              KIND_ONCE, KIND_REPEAT: begin
                if (!free_any) begin
                  res_q <= '{OUT_NO_SLOT, 5'd0, 1'b1};
                end else begin
                  free_q   <= free_idx;
                  per_in_q <= (kind_i == KIND_REPEAT);
                  amt_q    <= delay_amount_i;
                  if (time_unit_i == UNIT_MS && delay_amount_i > 24'(DELAY_MAX)) begin
                    su_q <= UNIT_S;
                    st_q <= ST_DIV;
                  end else begin
                    su_q <= (time_unit_i == 2'd3) ? UNIT_US : time_unit_i;
                    st_q <= ST_SCHED;
                  end
                end
              end
              default: begin
                if (32'(slot_id_i) < SLOTS) begin
                  busy_q[SW'(slot_id_i)] <= 1'b0;
                  per_q[SW'(slot_id_i)]  <= 1'b0;
                  res_q <= '{OUT_CANCELLED, slot_id_i, 1'b1};
                end else begin
                  res_q <= '{OUT_IGNORED, slot_id_i, 1'b1};
                end
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            amt_q <= div_q;
            st_q  <= ST_SCHED;
          end
        end
        ST_SCHED: begin
          if (can_put) begin
            delay_q[free_q] <= (amt_q > 24'(DELAY_MAX)) ? DW'(DELAY_MAX) : DW'(amt_q);
            unit_q[free_q]  <= su_q;
            start_q[free_q] <= (su_q == UNIT_US) ? micro_q : milli_q;
            busy_q[free_q]  <= 1'b1;
            per_q[free_q]   <= per_in_q;
            res_q <= '{OUT_SCHEDULED, 5'(free_q), 1'b1};
            st_q  <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          // snapshot readiness and lateness, one slot a cycle
          ready_q[idx_q] <= rdy;
          late_q[idx_q]  <= late;
          if (last_idx) begin
            idx_q    <= '0;
            pick_v_q <= 1'b0;
            st_q     <= ST_PICK;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end
        ST_PICK: begin
          // running maximum of lateness over the ready set
          if (ready_q[idx_q] && (!pick_v_q || late_q[idx_q] > best_q)) begin
            pick_v_q <= 1'b1;
            pick_q   <= idx_q;
            best_q   <= late_q[idx_q];
          end
          if (last_idx) begin
            st_q <= ST_EMIT;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end
        ST_EMIT: begin
          if (can_put) begin
            idx_q <= '0;
            if (!pick_v_q) begin
              res_q <= '{fired_q ? OUT_FIRED : OUT_NONE, 5'd0, 1'b1};
              st_q  <= ST_IDLE;
            end else begin
              ready_q[pick_q] <= 1'b0;
              if (per_q[pick_q]) begin
                start_q[pick_q] <= (unit_q[pick_q] == UNIT_US) ? micro_q : milli_q;
              end else begin
                busy_q[pick_q] <= 1'b0;
              end
              res_q    <= '{OUT_FIRED, 5'(pick_q),
                            ($countones(ready_q) == 1)};
              fired_q  <= 1'b1;
              pick_v_q <= 1'b0;
              st_q     <= ($countones(ready_q) == 1) ? ST_IDLE : ST_PICK;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_ALWAYS(a_stall_busy, clk_i, rst_ni, (st_q != ST_IDLE) |-> in_stall_o)
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, rv_q && out_stall_i, rv_q && $stable(res_q))
  `ASSERT_ALWAYS(a_emit_ready, clk_i, rst_ni,
    (st_q == ST_EMIT && pick_v_q) |-> ready_q[pick_q])
endmodule

### verif/mstt_checker.sv
// Checker for the multi-slot task timer: watches both channels, predicts results, compares.
// Depends on mstt_pkg.
module mstt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [23:0] delay_amount_i,
  input  logic [1:0]  time_unit_i,
  input  logic [4:0]  slot_id_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  outcome_i,
  input  logic [4:0]  slot_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          fired_seen_o
);
  import mstt_pkg::*;
  localparam int NSLOT = SlotsDef;

  // predicted timer state
  logic [31:0] us_now, ms_now;
  logic [9:0]  us_div;
  logic [31:0] t_start [NSLOT];
  logic [11:0] t_delay [NSLOT];
  logic [1:0]  t_unit  [NSLOT];
  logic        t_busy  [NSLOT];
  logic        t_rep   [NSLOT];

  result_t expected_results[$];

  function automatic logic [31:0] now_of(logic [1:0] u);
    return (u == UNIT_US) ? us_now : ms_now;
  endfunction

  function automatic void push_res(logic [2:0] oc, logic [4:0] sl, logic la);
    result_t r;
    r.outcome = oc; r.slot = sl; r.last = la;
    expected_results.push_back(r);
  endfunction

  // advance time and fire ready slots, most overdue first
  task automatic predict_tick();
    logic        rdy [NSLOT];
    logic [63:0] lateness [NSLOT];
    logic [31:0] el, need;
    int pick, n;
    n = 0;
    us_now = us_now + 1;
    us_div = us_div + 1;
    if (us_div >= 10'd1000) begin
      us_div = 0;
      ms_now = ms_now + 1;
    end
    for (int s = 0; s < NSLOT; s++) begin
      rdy[s] = 0; lateness[s] = 0;
      if (t_busy[s]) begin
        el = now_of(t_unit[s]) - t_start[s];
        need = (t_unit[s] == UNIT_S) ? t_delay[s] * 32'd1000 : 32'(t_delay[s]);
        if (el >= need) begin
          rdy[s] = 1;
          lateness[s] = 64'(el - need);
          if (t_unit[s] != UNIT_US) lateness[s] = lateness[s] * 1000;
        end
      end
    end
    forever begin
      pick = -1;
      for (int s = 0; s < NSLOT; s++)
        if (rdy[s] && (pick < 0 || lateness[s] > lateness[pick])) pick = s;
      if (pick < 0) break;
      rdy[pick] = 0;
      if (t_rep[pick]) t_start[pick] = now_of(t_unit[pick]);
      else t_busy[pick] = 0;
      push_res(OUT_FIRED, 5'(pick), 0);
      n++;
    end
    if (n == 0) push_res(OUT_NONE, 0, 1);
    else expected_results[$].last = 1;
  endtask

  task automatic predict_schedule(logic [23:0] amt, logic [1:0] u_in, logic rep);
    int found;
    logic [1:0]  u;
    logic [23:0] v;
    found = -1;
    for (int s = 0; s < NSLOT; s++)
      if (!t_busy[s] && found < 0) found = s;
    if (found < 0) begin
      push_res(OUT_NO_SLOT, 0, 1);
    end else begin
      u = (u_in == 2'd3) ? UNIT_US : u_in;
      v = amt;
      if (u == UNIT_MS && v > DelayMaxDef) begin
        u = UNIT_S;
        v = v / 1000;
      end
      if (v > DelayMaxDef) v = DelayMaxDef;
      t_delay[found] = v[11:0];
      t_unit[found]  = u;
      t_start[found] = now_of(u);
      t_busy[found]  = 1;
      t_rep[found]   = rep;
      push_res(OUT_SCHEDULED, 5'(found), 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      us_now <= 0; ms_now <= 0; us_div <= 0;
      for (int s = 0; s < NSLOT; s++) begin
        t_busy[s] <= 0; t_rep[s] <= 0; t_start[s] <= 0; t_delay[s] <= 0; t_unit[s] <= 0;
      end
      fail_count_o <= 0;
      fired_seen_o <= 0;
      pending_o    <= 0;
      expected_results.delete();
    end else begin
      // output transaction first: its expectation was queued by an earlier input
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result outcome=%0d slot=%0d last=%0d",
                   $time, outcome_i, slot_i, last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.outcome !== outcome_i || exp_r.slot !== slot_i || exp_r.last !== last_i) begin
            $display("%0t: mismatch expected outcome=%0d slot=%0d last=%0d, got %0d %0d %0d",
                     $time, exp_r.outcome, exp_r.slot, exp_r.last, outcome_i, slot_i, last_i);
            fail_count_o <= fail_count_o + 1;
          end
          if (outcome_i == OUT_FIRED) fired_seen_o <= fired_seen_o + 1;
        end
      end
      // input transaction
      if (in_valid_i && !in_stall_i) begin
        case (kind_i)
          KIND_TICK:   predict_tick();
          KIND_ONCE:   predict_schedule(delay_amount_i, time_unit_i, 0);
          KIND_REPEAT: predict_schedule(delay_amount_i, time_unit_i, 1);
          default: begin
            if (slot_id_i < NSLOT) begin
              t_busy[slot_id_i] = 0;
              t_rep[slot_id_i]  = 0;
              push_res(OUT_CANCELLED, slot_id_i, 1);
            end else begin
              push_res(OUT_IGNORED, slot_id_i, 1);
            end
          end
        endcase
      end
      pending_o <= expected_results.size();
    end
  end
endmodule

### verif/tb_multi_slot_task_timer_top.sv
// Testbench top for the multi-slot task timer: clock, reset, stimulus and verdict.
// Depends on mstt_pkg, multi_slot_task_timer_top and mstt_checker.
module tb_multi_slot_task_timer_top;
  import mstt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  kind_i;
  logic [23:0] delay_amount_i;
  logic [1:0]  time_unit_i;
  logic [4:0]  slot_id_i;
  logic        out_valid_o, out_stall_i;
  logic [2:0]  outcome_o;
  logic [4:0]  slot_o;
  logic        last_o;
  int          fail_count, pending, fired_seen;
  int          items_sent, idle_cycles;
  int          rx_wait;
  logic        long_hold;

  multi_slot_task_timer_top u_top (.*);

  mstt_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .delay_amount_i,
    .time_unit_i, .slot_id_i, .out_valid_i(out_valid_o), .out_stall_i, .outcome_i(outcome_o),
    .slot_i(slot_o), .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending),
    .fired_seen_o(fired_seen)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // drive one input transaction, with a random gap ahead of it; valid stays up after it
  task automatic send_item(logic [1:0] k, logic [23:0] amt, logic [1:0] u, logic [4:0] id,
                           bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1;
    kind_i         <= k;
    delay_amount_i <= amt;
    time_unit_i    <= u;
    slot_id_i      <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_item(KIND_TICK, 0, 0, 0);
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // random schedule with mostly short delays so firings are frequent
  task automatic rand_schedule();
    logic [23:0] amt;
    logic [1:0]  u;
    u = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       amt = 24'($urandom);
      1:       amt = 24'($urandom_range(4090, 5000));
      default: amt = 24'($urandom_range(0, 12));
    endcase
    if (u == UNIT_S || u == UNIT_MS) if ($urandom_range(0, 3) != 0) amt = 0;
    send_item($urandom_range(0, 1) ? KIND_ONCE : KIND_REPEAT, amt, u, 5'($urandom));
  endtask

  // receiver stall: a wait drawn per result, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    int w;
    if (!rst_ni) begin
      out_stall_i <= 0;
      rx_wait     <= 0;
    end else if (long_hold) begin
      out_stall_i <= 1;
    end else if (out_valid_o && !out_stall_i) begin
      w = $urandom_range(0, 3);
      rx_wait     <= w;
      out_stall_i <= (w != 0);
    end else if (rx_wait > 0) begin
      rx_wait     <= rx_wait - 1;
      out_stall_i <= (rx_wait > 1);
    end else begin
      out_stall_i <= 0;
    end
  end

  // watchdog on cycles with no transaction on either side, outside the long hold-off
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || long_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_multi_slot_task_timer_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 0; in_valid_i = 0; kind_i = 0; delay_amount_i = 0; time_unit_i = 0;
    slot_id_i = 0; long_hold = 0; items_sent = 0; idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty tick, extremes, zero delay, unit three, full table, cancels
    send_item(KIND_TICK, 0, 0, 0);
    send_item(KIND_ONCE, 0, UNIT_US, 0);
    send_item(KIND_REPEAT, 1, UNIT_US, 0);
    send_item(KIND_ONCE, 24'hFFFFFF, UNIT_MS, 0);
    send_item(KIND_ONCE, 4096, UNIT_MS, 0);
    send_item(KIND_REPEAT, 24'hFFFFFF, UNIT_US, 0);
    send_item(KIND_ONCE, 2, 2'd3, 0);
    send_item(KIND_REPEAT, 0, UNIT_S, 0);
    send_item(KIND_ONCE, 4095, UNIT_S, 0);
    send_item(KIND_ONCE, 5, UNIT_US, 0);
    send_ticks(4);
    send_item(KIND_CANCEL, 0, 0, 5'd7);
    send_item(KIND_CANCEL, 0, 0, 5'd31);
    send_item(KIND_CANCEL, 0, 0, 5'd8);
    send_item(KIND_CANCEL, 0, 0, 5'd0);
    send_item(KIND_CANCEL, 24'hFFFFFF, 2'd3, 5'd5);
    for (int s = 0; s < 8; s++) send_item(KIND_CANCEL, 0, 0, 5'(s));
    drain();

    // receiver holds off while the sender keeps offering
    fork
      begin
        long_hold = 1;
        repeat (300) @(posedge clk_i);
        long_hold = 0;
      end
      for (int i = 0; i < 12; i++) send_item(i % 2 ? KIND_TICK : KIND_REPEAT, 0, UNIT_US, 0, 1);
    join
    drain();

    // random: mostly schedule/tick mixes, some cancels
    for (int i = 0; i < 220; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    rand_schedule();
        3:          send_item(KIND_CANCEL, 24'($urandom), 2'($urandom), 5'($urandom));
        4:          send_item(KIND_CANCEL, 0, 0, 5'($urandom_range(0, 7)));
        default:    send_ticks($urandom_range(1, 3));
      endcase
      if (i == 110) drain();
    end
    drain();
    repeat (200) begin
      @(posedge clk_i);
      if (pending != 0) drain();
    end

    $display("Sent %0d items: directed corners, full table, a long receiver hold-off and",
             items_sent);
    $display("random traffic; %0d slot firings checked.", fired_seen);
    if (fail_count == 0) begin
      $display("tb_multi_slot_task_timer_top: PASS");
    end else begin
      $display("tb_multi_slot_task_timer_top: FAIL");
    end
    $finish;
  end
endmodule
